### rtl/rmm_pkg.sv
`timescale 1ns / 1ps

package rmm_pkg;

    localparam int MAX_SIDE = 63;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int REGION_W = 11;
    localparam int SIDE_W = 6;
    localparam int ZONE_W = 10;
    localparam int HALF_W = SIDE_W - 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [REGION_W-1:0] WALL_CODE = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TRY = 1'b1;

    localparam logic [SIDE_W-1:0] GRID_WIDTH_RESET = 6'd21;
    localparam logic [SIDE_W-1:0] GRID_HEIGHT_RESET = 6'd31;

    typedef struct packed {
        logic              operation;
        logic [SIDE_W-1:0] pos_x;
        logic [SIDE_W-1:0] pos_y;
        logic              horizontal_pick;
    } maze_in_t;

    typedef struct packed {
        logic              wall_opened;
        logic [ZONE_W-1:0] zones_left;
        logic              finished;
    } maze_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAYOUT,
        ST_TRY_CHECK,
        ST_READ_A,
        ST_READ_B,
        ST_COMPARE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_REPLY
    } rmm_state_t;

    typedef struct packed {
        logic accept;
        logic layout_step;
        logic read_center;
        logic read_a;
        logic read_b;
        logic latch_a;
        logic compare_write;
        logic scan_step;
        logic scan_tail;
        logic reply;
    } rmm_cmd_t;

    typedef struct packed {
        logic op_is_start;
        logic try_ok;
        logic center_wall;
        logic pair_ok;
        logic sweep_last;
    } rmm_status_t;

    // Clamp to the legal side range, then force an odd side.
    function automatic logic [SIDE_W-1:0] effective_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] s;
        s = v;
        if (s < SIDE_W'(3))
        begin
            s = SIDE_W'(3);
        end
        if (s > SIDE_W'(MAX_SIDE))
        begin
            s = SIDE_W'(MAX_SIDE);
        end
        if (!s[0])
        begin
            s = s - SIDE_W'(1);
        end
        return s;
    endfunction

endpackage

### rtl/rmm_ram.sv
`timescale 1ns / 1ps

module rmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rmm_datapath.sv
`timescale 1ns / 1ps

module rmm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rmm_pkg::maze_in_t                 request,
    input  logic                              cfg_we,
    input  logic [rmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rmm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  rmm_pkg::rmm_cmd_t                 cmd,
    output rmm_pkg::rmm_status_t              status,
    output rmm_pkg::maze_out_t                result,
    output logic                              done
);

    import rmm_pkg::*;

    logic [SIDE_W-1:0]   grid_w_reg, grid_w_next;
    logic [SIDE_W-1:0]   grid_h_reg, grid_h_next;
    logic [SIDE_W-1:0]   used_w_reg, used_w_next;
    logic [SIDE_W-1:0]   used_h_reg, used_h_next;
    logic [ZONE_W-1:0]   merges_reg, merges_next;
    logic                opened_reg, opened_next;
    logic                done_reg, done_next;
    logic                pend_reg, pend_next;
    maze_in_t            item_reg, item_next;
    maze_out_t           result_reg, result_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic [ADDR_W-1:0]   prev_reg, prev_next;
    logic [SIDE_W-1:0]   col_reg, col_next;
    logic [SIDE_W-1:0]   row_reg, row_next;
    logic [REGION_W-1:0] next_id_reg, next_id_next;
    logic [REGION_W-1:0] a_reg, a_next;
    logic [REGION_W-1:0] b_reg, b_next;

    logic [ADDR_W-1:0]   center_addr;
    logic [ADDR_W-1:0]   step;
    logic [ADDR_W-1:0]   a_addr;
    logic [ADDR_W-1:0]   b_addr;
    logic                room;
    logic [HALF_W-1:0]   half_w;
    logic [HALF_W-1:0]   half_h;
    logic [ZONE_W-1:0]   room_count;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [REGION_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [REGION_W-1:0] ram_rdata;
    logic                scan_hit;

    rmm_ram #(
        .WIDTH (REGION_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign center_addr = ADDR_W'(item_reg.pos_y) * ADDR_W'(MAX_SIDE)
                         + ADDR_W'(item_reg.pos_x);
    assign step = item_reg.horizontal_pick ? ADDR_W'(1) : ADDR_W'(MAX_SIDE);
    assign a_addr = center_addr - step;
    assign b_addr = center_addr + step;

    assign room = (col_reg < used_w_reg) && (row_reg < used_h_reg)
                  && col_reg[0] && row_reg[0];

    assign half_w = HALF_W'((used_w_reg - SIDE_W'(1)) >> 1);
    assign half_h = HALF_W'((used_h_reg - SIDE_W'(1)) >> 1);
    assign room_count = ZONE_W'(half_w) * ZONE_W'(half_h);

    assign scan_hit = pend_reg && (ram_rdata == b_reg);

    always_comb
    begin
        status.op_is_start = (request.operation == OP_START);
        status.try_ok = (merges_reg != '0)
                        && (item_reg.pos_x > '0) && (item_reg.pos_y > '0)
                        && (item_reg.pos_x < used_w_reg - SIDE_W'(1))
                        && (item_reg.pos_y < used_h_reg - SIDE_W'(1));
        status.center_wall = (ram_rdata == WALL_CODE);
        status.pair_ok = (a_reg != ram_rdata) && (a_reg != WALL_CODE)
                         && (ram_rdata != WALL_CODE);
        status.sweep_last = (sweep_reg == ADDR_W'(CELLS - 1));
    end

    always_comb
    begin
        priority if (cmd.read_center)
        begin
            ram_raddr = center_addr;
        end
        else if (cmd.read_a)
        begin
            ram_raddr = a_addr;
        end
        else if (cmd.read_b)
        begin
            ram_raddr = b_addr;
        end
        else
        begin
            ram_raddr = sweep_reg;
        end
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = room ? next_id_reg : WALL_CODE;
        priority if (cmd.layout_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.compare_write)
        begin
            ram_we = 1'b1;
            ram_waddr = center_addr;
            ram_wdata = a_reg;
        end
        else if ((cmd.scan_step || cmd.scan_tail) && scan_hit)
        begin
            // The scan writes one cell behind the read it just issued.
            ram_we = 1'b1;
            ram_waddr = prev_reg;
            ram_wdata = a_reg;
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    always_comb
    begin
        grid_w_next = grid_w_reg;
        grid_h_next = grid_h_reg;
        used_w_next = used_w_reg;
        used_h_next = used_h_reg;
        merges_next = merges_reg;
        opened_next = opened_reg;
        done_next = 1'b0;
        pend_next = 1'b0;
        item_next = item_reg;
        result_next = result_reg;
        sweep_next = sweep_reg;
        prev_next = prev_reg;
        col_next = col_reg;
        row_next = row_reg;
        next_id_next = next_id_reg;
        a_next = a_reg;
        b_next = b_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_w_next = SIDE_W'(cfg_data);
                CFG_GRID_HEIGHT: grid_h_next = SIDE_W'(cfg_data);
                default:         grid_w_next = grid_w_reg;
            endcase
        end

        if (cmd.accept)
        begin
            item_next = request;
            opened_next = 1'b0;
            sweep_next = '0;
            col_next = '0;
            row_next = '0;
            next_id_next = '0;
            if (request.operation == OP_START)
            begin
                used_w_next = effective_side(grid_w_reg);
                used_h_next = effective_side(grid_h_reg);
            end
        end

        if (cmd.layout_step)
        begin
            sweep_next = sweep_reg + ADDR_W'(1);
            if (room)
            begin
                next_id_next = next_id_reg + REGION_W'(1);
            end
            if (col_reg == SIDE_W'(MAX_SIDE - 1))
            begin
                col_next = '0;
                row_next = row_reg + SIDE_W'(1);
            end
            else
            begin
                col_next = col_reg + SIDE_W'(1);
            end
            if (status.sweep_last)
            begin
                merges_next = room_count - ZONE_W'(1);
            end
        end

        if (cmd.latch_a)
        begin
            a_next = ram_rdata;
        end

        if (cmd.compare_write)
        begin
            b_next = ram_rdata;
            sweep_next = '0;
        end

        if (cmd.scan_step)
        begin
            prev_next = sweep_reg;
            pend_next = 1'b1;
            sweep_next = sweep_reg + ADDR_W'(1);
        end

        if (cmd.scan_tail)
        begin
            merges_next = merges_reg - ZONE_W'(1);
            opened_next = 1'b1;
        end

        if (cmd.reply)
        begin
            result_next.wall_opened = opened_reg;
            result_next.zones_left = merges_reg;
            result_next.finished = (merges_reg == '0);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= GRID_WIDTH_RESET;
            grid_h_reg <= GRID_HEIGHT_RESET;
            used_w_reg <= effective_side(GRID_WIDTH_RESET);
            used_h_reg <= effective_side(GRID_HEIGHT_RESET);
            merges_reg <= '0;
            opened_reg <= 1'b0;
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            grid_w_reg <= grid_w_next;
            grid_h_reg <= grid_h_next;
            used_w_reg <= used_w_next;
            used_h_reg <= used_h_next;
            merges_reg <= merges_next;
            opened_reg <= opened_next;
            done_reg <= done_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        result_reg <= result_next;
        sweep_reg <= sweep_next;
        prev_reg <= prev_next;
        col_reg <= col_next;
        row_reg <= row_next;
        next_id_reg <= next_id_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign result = result_reg;
    assign done = done_reg;

endmodule

### rtl/rmm_ctrl.sv
`timescale 1ns / 1ps

module rmm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rmm_pkg::rmm_status_t status,
    output rmm_pkg::rmm_cmd_t    cmd,
    output logic                 busy
);

    import rmm_pkg::*;

    rmm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.op_is_start ? ST_LAYOUT : ST_TRY_CHECK;
                end
            end
            ST_LAYOUT:
            begin
                cmd.layout_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_TRY_CHECK:
            begin
                cmd.read_center = 1'b1;
                state_next = status.try_ok ? ST_READ_A : ST_REPLY;
            end
            ST_READ_A:
            begin
                // Read data now holds the candidate cell.
                cmd.read_a = 1'b1;
                state_next = status.center_wall ? ST_READ_B : ST_REPLY;
            end
            ST_READ_B:
            begin
                cmd.read_b = 1'b1;
                cmd.latch_a = 1'b1;
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (status.pair_ok)
                begin
                    cmd.compare_write = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL:
            begin
                cmd.scan_tail = 1'b1;
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                cmd.reply = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/random_maze_region_merge.sv
`timescale 1ns / 1ps

// Channel   Ports                          Transfer
// request   start, busy, request           taken at a clock edge with start high, busy low
// result    done, result                   done high for one cycle, result valid with it
// config    cfg_we, cfg_index, cfg_data    written at a clock edge with cfg_we high
//
// A start request sweeps all MAX_SIDE * MAX_SIDE region store cells, one per cycle,
// and answers once the sweep is done. A rejected try answers without a rescan;
// an opened wall rescans the store one cell per cycle through the RAM's registered
// read port and answers once the rescan is done. After reset the block
// reports finished and ignores tries until a start request lays out a grid.
// The receiver cannot stall: done marks each result for exactly one cycle.

module random_maze_region_merge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  rmm_pkg::maze_in_t              request,
    output logic                           done,
    output rmm_pkg::maze_out_t             result,
    input  logic                           cfg_we,
    input  logic [rmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmm_pkg::CFG_DATA_W-1:0] cfg_data
);

    import rmm_pkg::*;

    rmm_cmd_t    cmd;
    rmm_status_t status;

    rmm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rmm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import rmm_pkg::*;

    localparam int RANDOM_ITEMS = 114;
    localparam int RUN_LIMIT = 3_000_000;

    typedef enum logic [1:0] {
        ROW_GRID,
        ROW_PREDICTED,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_DATA_W-1:0] width_val;
        logic [CFG_DATA_W-1:0] height_val;
        maze_in_t              req;
        maze_out_t             want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    maze_in_t              request = '0;
    logic                  done;
    maze_out_t             result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Our own copy of the maze: one region id per cell, plus the merge count.
    logic [REGION_W-1:0]   cell_region [CELLS];
    int unsigned           merges_pending;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int unsigned           side_w;
    int unsigned           side_h;

    maze_out_t             maze_replies_due [$];
    plan_row_t             directed_plan [$];
    bit                    gapless = 1'b0;
    int                    mismatches = 0;
    int                    requests_sent = 0;
    int                    starts_sent = 0;
    int                    walls_opened = 0;
    int                    mazes_completed = 0;
    int unsigned           cycle_count = 0;

    random_maze_region_merge u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int unsigned odd_side(input logic [CFG_DATA_W-1:0] raw);
        int unsigned s;
        s = 32'(raw);
        if (s < 3)
        begin
            s = 3;
        end
        if (s > MAX_SIDE)
        begin
            s = MAX_SIDE;
        end
        if (s % 2 == 0)
        begin
            s = s - 1;
        end
        return s;
    endfunction

    function automatic void lay_out_grid();
        int unsigned room_id;
        int unsigned idx;
        room_id = 0;
        side_w = odd_side(width_reg);
        side_h = odd_side(height_reg);
        for (int y = 0; y < MAX_SIDE; y++)
        begin
            for (int x = 0; x < MAX_SIDE; x++)
            begin
                idx = y * MAX_SIDE + x;
                if (x < side_w && y < side_h && x % 2 == 1 && y % 2 == 1)
                begin
                    cell_region[idx] = REGION_W'(room_id);
                    room_id++;
                end
                else
                begin
                    cell_region[idx] = WALL_CODE;
                end
            end
        end
        merges_pending = ((side_w - 1) * (side_h - 1)) / 4 - 1;
    endfunction

    // Applies one request to the maze copy and returns the reply it should give.
    function automatic maze_out_t advance_maze(input maze_in_t req);
        maze_out_t           reply;
        int unsigned         x;
        int unsigned         y;
        int unsigned         dx;
        int unsigned         dy;
        logic [REGION_W-1:0] keep_id;
        logic [REGION_W-1:0] gone_id;
        reply = '0;
        x = 32'(req.pos_x);
        y = 32'(req.pos_y);
        if (req.operation == OP_START)
        begin
            lay_out_grid();
        end
        else if (merges_pending != 0)
        begin
            if (x > 0 && y > 0 && x < side_w - 1 && y < side_h - 1 &&
                cell_region[y * MAX_SIDE + x] == WALL_CODE)
            begin
                dx = req.horizontal_pick ? 1 : 0;
                dy = req.horizontal_pick ? 0 : 1;
                keep_id = cell_region[(y - dy) * MAX_SIDE + (x - dx)];
                gone_id = cell_region[(y + dy) * MAX_SIDE + (x + dx)];
                if (keep_id != gone_id && keep_id != WALL_CODE && gone_id != WALL_CODE)
                begin
                    cell_region[y * MAX_SIDE + x] = keep_id;
                    for (int i = 0; i < CELLS; i++)
                    begin
                        if (cell_region[i] == gone_id)
                        begin
                            cell_region[i] = keep_id;
                        end
                    end
                    merges_pending--;
                    reply.wall_opened = 1'b1;
                end
            end
        end
        reply.zones_left = ZONE_W'(merges_pending);
        reply.finished = (merges_pending == 0);
        return reply;
    endfunction

    function automatic maze_in_t make_request(input logic op, input int x, input int y,
                                              input int hz);
        maze_in_t req;
        req.operation = op;
        req.pos_x = SIDE_W'(x);
        req.pos_y = SIDE_W'(y);
        req.horizontal_pick = hz[0];
        return req;
    endfunction

    function automatic plan_row_t plan_grid(input int w, input int h);
        plan_row_t row;
        row = '0;
        row.kind = ROW_GRID;
        row.width_val = CFG_DATA_W'(w);
        row.height_val = CFG_DATA_W'(h);
        return row;
    endfunction

    function automatic plan_row_t plan_item(input logic op, input int x, input int y,
                                            input int hz);
        plan_row_t row;
        row = '0;
        row.kind = ROW_PREDICTED;
        row.req = make_request(op, x, y, hz);
        return row;
    endfunction

    function automatic plan_row_t plan_checked(input logic op, input int x, input int y,
                                               input int hz, input int opened,
                                               input int zones, input int fin);
        plan_row_t row;
        row = plan_item(op, x, y, hz);
        row.kind = ROW_TYPED;
        row.want.wall_opened = opened[0];
        row.want.zones_left = ZONE_W'(zones);
        row.want.finished = fin[0];
        return row;
    endfunction

    // Presents one request and returns at the edge where the block takes it.
    task automatic issue_request(input maze_in_t req, input bit typed,
                                 input maze_out_t typed_want);
        int        hold;
        maze_out_t want;
        hold = gapless ? 0 : $urandom_range(0, 4);
        if (hold > 0)
        begin
            start <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        want = advance_maze(req);
        requests_sent++;
        if (req.operation == OP_START)
        begin
            starts_sent++;
        end
        if (want.wall_opened)
        begin
            walls_opened++;
            if (want.finished)
            begin
                mazes_completed++;
            end
        end
        maze_replies_due.push_back(typed ? typed_want : want);
    endtask

    // Every request gets a reply, so an empty queue with busy low means idle.
    task automatic drain;
        start <= 1'b0;
        do
            @(posedge clk);
        while (maze_replies_due.size() != 0 || busy);
    endtask

    task automatic program_grid(input logic [CFG_DATA_W-1:0] w,
                                input logic [CFG_DATA_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    always @(posedge clk)
    begin : check_replies
        maze_out_t want;
        if (rst_n && done)
        begin
            if (maze_replies_due.size() == 0)
            begin
                $display("%0t: reply with none outstanding: opened=%0d zones=%0d finished=%0d",
                         $time, result.wall_opened, result.zones_left, result.finished);
                mismatches++;
            end
            else
            begin
                want = maze_replies_due.pop_front();
                if (result.wall_opened !== want.wall_opened ||
                    result.zones_left !== want.zones_left ||
                    result.finished !== want.finished)
                begin
                    $display("%0t: expected opened=%0d zones=%0d finished=%0d, got %0d %0d %0d",
                             $time, want.wall_opened, want.zones_left, want.finished,
                             result.wall_opened, result.zones_left, result.finished);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles without finishing", $time, RUN_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : main_flow
        maze_in_t  req;
        plan_row_t row;
        int        counted;
        int        pick;
        int        w;
        int        h;
        int        tries;

        width_reg = GRID_WIDTH_RESET;
        height_reg = GRID_HEIGHT_RESET;
        lay_out_grid();
        merges_pending = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tries before any start are ignored, then the reset size of 21 by 31.
        directed_plan.push_back(plan_checked(OP_TRY, 1, 2, 0, 0, 0, 1));
        directed_plan.push_back(plan_checked(OP_START, 63, 0, 1, 0, 149, 0));
        directed_plan.push_back(plan_checked(OP_TRY, 2, 1, 1, 1, 148, 0));
        directed_plan.push_back(plan_checked(OP_TRY, 2, 1, 1, 0, 148, 0));
        directed_plan.push_back(plan_checked(OP_TRY, 0, 1, 1, 0, 148, 0));
        directed_plan.push_back(plan_checked(OP_TRY, 63, 63, 1, 0, 148, 0));
        directed_plan.push_back(plan_item(OP_TRY, 1, 1, 0));
        directed_plan.push_back(plan_item(OP_TRY, 2, 2, 1));
        // A new size must not apply before the next start.
        directed_plan.push_back(plan_grid(3, 3));
        directed_plan.push_back(plan_item(OP_TRY, 4, 1, 1));
        directed_plan.push_back(plan_checked(OP_START, 0, 63, 0, 0, 0, 1));
        directed_plan.push_back(plan_checked(OP_TRY, 1, 2, 0, 0, 0, 1));
        directed_plan.push_back(plan_grid(63, 63));
        directed_plan.push_back(plan_checked(OP_START, 0, 0, 0, 0, 960, 0));
        directed_plan.push_back(plan_item(OP_TRY, 61, 62, 0));
        directed_plan.push_back(plan_checked(OP_TRY, 61, 60, 0, 1, 959, 0));
        // Sides below the legal range are clamped up to three.
        directed_plan.push_back(plan_grid(2, 0));
        directed_plan.push_back(plan_checked(OP_START, 5, 5, 1, 0, 0, 1));
        // An even height drops to five; the fourth try closes a loop in one region.
        directed_plan.push_back(plan_grid(7, 6));
        directed_plan.push_back(plan_item(OP_START, 1, 1, 0));
        directed_plan.push_back(plan_item(OP_TRY, 2, 1, 1));
        directed_plan.push_back(plan_item(OP_TRY, 1, 2, 0));
        directed_plan.push_back(plan_item(OP_TRY, 3, 2, 0));
        directed_plan.push_back(plan_item(OP_TRY, 2, 3, 1));
        directed_plan.push_back(plan_item(OP_TRY, 5, 2, 0));
        directed_plan.push_back(plan_item(OP_TRY, 4, 1, 1));
        directed_plan.push_back(plan_item(OP_TRY, 4, 3, 1));

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_GRID)
            begin
                drain();
                program_grid(row.width_val, row.height_val);
            end
            else
            begin
                issue_request(row.req, row.kind == ROW_TYPED, row.want);
            end
        end

        // Random phases: a new size, a start, then mostly tries aimed at real walls.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                w = $urandom_range(0, 63);
                h = $urandom_range(0, 63);
            end
            else if (pick == 1)
            begin
                w = 63;
                h = $urandom_range(3, 9);
            end
            else
            begin
                w = $urandom_range(3, 11);
                h = $urandom_range(3, 11);
            end
            drain();
            program_grid(CFG_DATA_W'(w), CFG_DATA_W'(h));
            gapless = ($urandom_range(0, 3) == 0);
            counted++;
            issue_request(make_request(OP_START, $urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 1)), 1'b0, '0);
            tries = $urandom_range(3, 14);
            repeat (tries)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 1)
                begin
                    req = make_request(OP_START, $urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 1));
                end
                else if (pick == 0 || (side_w < 5 && side_h < 5))
                begin
                    req = make_request(OP_TRY, $urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 1));
                end
                else
                begin
                    req.operation = OP_TRY;
                    req.horizontal_pick = $urandom_range(0, 1);
                    if (side_w < 5)
                    begin
                        req.horizontal_pick = 1'b0;
                    end
                    if (side_h < 5)
                    begin
                        req.horizontal_pick = 1'b1;
                    end
                    // A wall between two rooms sits on an even column or an even row.
                    if (req.horizontal_pick)
                    begin
                        req.pos_x = SIDE_W'(2 * $urandom_range(1, (side_w - 3) / 2));
                        req.pos_y = SIDE_W'(2 * $urandom_range(0, (side_h - 3) / 2) + 1);
                    end
                    else
                    begin
                        req.pos_x = SIDE_W'(2 * $urandom_range(0, (side_w - 3) / 2) + 1);
                        req.pos_y = SIDE_W'(2 * $urandom_range(1, (side_h - 3) / 2));
                    end
                end
                counted++;
                issue_request(req, 1'b0, '0);
            end
        end

        drain();
        repeat (CELLS + 16) @(posedge clk);

        $display("Sent %0d requests including %0d starts over random grid sizes from 3 to 63;",
                 requests_sent, starts_sent);
        $display("%0d walls opened, %0d mazes carried to completion, %0d mismatches.",
                 walls_opened, mazes_completed, mismatches);
        if (mismatches == 0 && maze_replies_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
